FILE: rtl/u2u8_pkg.sv
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types and codes of the UTF-16 / UTF-32 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

    // Source encoding selector values
    localparam logic [2:0] ENC_UTF8     = 3'd0;
    localparam logic [2:0] ENC_UTF16_LE = 3'd1;
    localparam logic [2:0] ENC_UTF16_BE = 3'd2;
    localparam logic [2:0] ENC_UTF32_LE = 3'd3;
    localparam logic [2:0] ENC_UTF32_BE = 3'd4;

    // Error codes reported on status results
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd1;
    localparam logic [2:0] ERR_HIGH_ALONE = 3'd2;
    localparam logic [2:0] ERR_LOW_ALONE  = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE  = 3'd4;

    // Depth of the job queue between the front and the back
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // One classified request: either up to four bytes or a single status
    typedef struct packed {
        logic [3:0][7:0] bytes;      // bytes[0] is sent first
        logic [1:0]      last_idx;   // number of bytes minus one
        logic            is_status;
        logic [2:0]      error_code;
        logic            stream_end;
    } job_t;

endpackage

FILE: rtl/u2u8_front.sv
// ----------------------------------------------------------------------------
// u2u8_front
// Accepts code units, tracks the pending high surrogate and classifies each
// request into a byte job or a status job.
// ----------------------------------------------------------------------------
module u2u8_front
    import u2u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  source_encoding,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] unit,
    input  logic [2:0]  valid_bytes,
    output logic        job_push,
    output job_t        job
);

    logic [2:0] enc_reg, enc_next;
    logic [9:0] pend_bits_reg, pend_bits_next;
    logic       pend_valid_reg, pend_valid_next;

    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] v16;
    logic [31:0] v32;
    logic        is_hi, is_lo;
    logic [20:0] pair_cp;
    logic        accept;
    logic        emit;

    // Build a status job
    function automatic job_t status_job(input logic [2:0] err, input logic fin);
        job_t j;
        j            = '0;
        j.is_status  = 1'b1;
        j.error_code = err;
        j.stream_end = fin;
        return j;
    endfunction

    // UTF-8 encoding of one code point
    function automatic job_t encode_cp(input logic [31:0] cp);
        job_t j;
        j = '0;
        if (cp < 32'h80) begin
            j.bytes[0] = cp[7:0];
            j.last_idx = 2'd0;
        end else if (cp < 32'h800) begin
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
            j.last_idx = 2'd1;
        end else if (cp < 32'h10000) begin
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
            j.last_idx = 2'd2;
        end else if (cp <= 32'h10FFFF) begin
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
            j.last_idx = 2'd3;
        end else begin
            j = status_job(ERR_TOO_LARGE, 1'b0);
        end
        return j;
    endfunction

    // Byte views of the unit in both orders
    assign b0 = unit[7:0];
    assign b1 = unit[15:8];
    assign b2 = unit[23:16];
    assign b3 = unit[31:24];

    assign v16     = (enc_reg == ENC_UTF16_LE) ? {b1, b0} : {b0, b1};
    assign v32     = (enc_reg == ENC_UTF32_LE) ? unit : {b0, b1, b2, b3};
    assign is_hi   = (v16[15:10] == 6'b110110);
    assign is_lo   = (v16[15:10] == 6'b110111);
    assign pair_cp = 21'h10000 + {1'b0, pend_bits_reg, v16[9:0]};
    assign accept  = in_valid && in_ready;

    // Classification of the current request and surrogate tracking
    always_comb
    begin
        enc_next        = enc_reg;
        pend_bits_next  = pend_bits_reg;
        pend_valid_next = pend_valid_reg;
        emit            = 1'b1;
        job             = '0;
        if (valid_bytes == 3'd0) begin
            if (pend_valid_reg) begin
                job = status_job(ERR_HIGH_ALONE, 1'b0);
            end else begin
                job = status_job(ERR_NONE, 1'b1);
            end
            pend_valid_next = 1'b0;
            pend_bits_next  = '0;
        end else if (valid_bytes > 3'd4) begin
            job             = status_job(ERR_INCOMPLETE, 1'b0);
            pend_valid_next = 1'b0;
            pend_bits_next  = '0;
        end else if (enc_reg == ENC_UTF16_LE || enc_reg == ENC_UTF16_BE) begin
            if (valid_bytes != 3'd2) begin
                job             = status_job(ERR_INCOMPLETE, 1'b0);
                pend_valid_next = 1'b0;
                pend_bits_next  = '0;
            end else if (pend_valid_reg) begin
                pend_valid_next = 1'b0;
                pend_bits_next  = '0;
                if (is_lo) begin
                    job = encode_cp({11'd0, pair_cp});
                end else begin
                    job = status_job(ERR_HIGH_ALONE, 1'b0);
                end
            end else if (is_hi) begin
                // High surrogate is held for the next unit
                emit            = 1'b0;
                pend_valid_next = 1'b1;
                pend_bits_next  = v16[9:0];
            end else if (is_lo) begin
                job = status_job(ERR_LOW_ALONE, 1'b0);
            end else begin
                job = encode_cp({16'd0, v16});
            end
        end else if (enc_reg == ENC_UTF32_LE || enc_reg == ENC_UTF32_BE) begin
            if (valid_bytes != 3'd4) begin
                job = status_job(ERR_INCOMPLETE, 1'b0);
            end else begin
                job = encode_cp(v32);
            end
        end else begin
            // Pass-through of the present bytes
            job.bytes    = unit;
            job.last_idx = 2'(valid_bytes - 3'd1);
        end

        if (!accept) begin
            pend_bits_next  = pend_bits_reg;
            pend_valid_next = pend_valid_reg;
        end
        // A register write selects the encoding and drops any surrogate
        if (cfg_valid) begin
            enc_next        = source_encoding;
            pend_valid_next = 1'b0;
            pend_bits_next  = '0;
        end
    end

    assign job_push = accept && emit;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enc_reg        <= ENC_UTF8;
            pend_bits_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            enc_reg        <= enc_next;
            pend_bits_reg  <= pend_bits_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

FILE: rtl/u2u8_queue.sv
// ----------------------------------------------------------------------------
// u2u8_queue
// Short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module u2u8_queue
    import u2u8_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t                slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCOUNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage needs no reset
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/u2u8_back.sv
// ----------------------------------------------------------------------------
// u2u8_back
// Serialises the job at the head of the queue into one result per cycle
// while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module u2u8_back
    import u2u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last,
    output logic [2:0] error_code,
    output logic       stream_end
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg;
    logic       bv_reg, last_reg, end_reg;
    logic [2:0] err_reg;
    logic       advance;
    logic       final_result;

    // A new result can be loaded whenever the output register is free
    assign advance      = !q_empty && (!out_valid_reg || out_ready);
    assign final_result = q_head.is_status || (idx_reg == q_head.last_idx);
    assign q_pop        = advance && final_result;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            idx_next       = final_result ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (advance) begin
            byte_reg <= q_head.is_status ? 8'd0 : q_head.bytes[idx_reg];
            bv_reg   <= !q_head.is_status;
            last_reg <= final_result;
            err_reg  <= q_head.is_status ? q_head.error_code : ERR_NONE;
            end_reg  <= q_head.is_status && q_head.stream_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bv_reg;
    assign last       = last_reg;
    assign error_code = err_reg;
    assign stream_end = end_reg;

endmodule

FILE: rtl/utf16_utf32_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_utf32_to_utf8_transcoder
// Re-encodes UTF-16 or UTF-32 code units (or passes UTF-8 through) as a
// stream of UTF-8 bytes, with error and end-of-stream reporting.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  config    cfg_valid / cfg_ready   source_encoding
//  input     in_valid / in_ready     unit, valid_bytes
//  output    out_valid / out_ready   out_byte, byte_valid, last,
//                                    error_code, stream_end
//
// A request is classified in the cycle it is accepted and queued at that edge;
// its job then passes through the queue and the output register, and its
// results follow at one per cycle while the output is not stalled. A held
// high surrogate yields nothing.
// A two-entry job queue lets the input side keep accepting while the output
// stalls. Reset leaves UTF-8 pass-through selected, no surrogate pending and
// the queue empty; the configuration port is always ready.
// ----------------------------------------------------------------------------
module utf16_utf32_to_utf8_transcoder
    import u2u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  source_encoding,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] unit,
    input  logic [2:0]  valid_bytes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        last,
    output logic [2:0]  error_code,
    output logic        stream_end
);

    logic job_push;
    job_t job;
    logic q_full, q_empty, q_pop;
    job_t q_head;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;

    // Front: accept and classify
    u2u8_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .source_encoding (source_encoding),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .unit            (unit),
        .valid_bytes     (valid_bytes),
        .job_push        (job_push),
        .job             (job)
    );

    // Job queue
    u2u8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Back: byte serialiser
    u2u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .error_code (error_code),
        .stream_end (stream_end)
    );

endmodule
